// ----- src/lrpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lrpc_pkg: shared types, codes and microprogram
// Control word layout, operation and condition codes, and the control store
// of the longest-run sequencer.
// ----------------------------------------------------------------------------
package lrpc_pkg;

  // result field widths
  localparam int START_W     = 10;
  localparam int LEN_W_OUT   = 11;
  localparam int OUT_TDATA_W = 24;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
  localparam logic [OP_W-1:0] OP_P_INIT    = 4'd1;  // divisor 2, square 4
  localparam logic [OP_W-1:0] OP_REM_P     = 4'd2;  // start a mod d
  localparam logic [OP_W-1:0] OP_REM_G     = 4'd3;  // start a mod b
  localparam logic [OP_W-1:0] OP_D_INC     = 4'd4;  // next trial divisor
  localparam logic [OP_W-1:0] OP_GCD_STEP  = 4'd5;  // a <= b, b <= remainder
  localparam logic [OP_W-1:0] OP_RUN_FIRST = 4'd6;
  localparam logic [OP_W-1:0] OP_RUN_GROW  = 4'd7;
  localparam logic [OP_W-1:0] OP_RUN_BREAK = 4'd8;
  localparam logic [OP_W-1:0] OP_FINISH    = 4'd9;

  // jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_NEVER    = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
  localparam logic [COND_W-1:0] C_NO_ITEM  = 4'd2;
  localparam logic [COND_W-1:0] C_FIRST    = 4'd3;
  localparam logic [COND_W-1:0] C_MODE1    = 4'd4;
  localparam logic [COND_W-1:0] C_LT2      = 4'd5;
  localparam logic [COND_W-1:0] C_SQ_GT    = 4'd6;
  localparam logic [COND_W-1:0] C_REM_BUSY = 4'd7;
  localparam logic [COND_W-1:0] C_REM_ZERO = 4'd8;
  localparam logic [COND_W-1:0] C_B_ZERO   = 4'd9;
  localparam logic [COND_W-1:0] C_A_ONE    = 4'd10;
  localparam logic [COND_W-1:0] C_OUT_BUSY = 4'd11;

  // program labels
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] ST_DISPATCH = 5'd1;
  localparam logic [STEP_W-1:0] ST_SEL_MODE = 5'd2;
  localparam logic [STEP_W-1:0] ST_P_INIT   = 5'd3;
  localparam logic [STEP_W-1:0] ST_P_LOOP   = 5'd4;
  localparam logic [STEP_W-1:0] ST_P_REM    = 5'd5;
  localparam logic [STEP_W-1:0] ST_P_WAIT   = 5'd6;
  localparam logic [STEP_W-1:0] ST_P_CHECK  = 5'd7;
  localparam logic [STEP_W-1:0] ST_P_NEXT   = 5'd8;
  localparam logic [STEP_W-1:0] ST_G_LOOP   = 5'd9;
  localparam logic [STEP_W-1:0] ST_G_REM    = 5'd10;
  localparam logic [STEP_W-1:0] ST_G_WAIT   = 5'd11;
  localparam logic [STEP_W-1:0] ST_G_STEP   = 5'd12;
  localparam logic [STEP_W-1:0] ST_G_CHECK  = 5'd13;
  localparam logic [STEP_W-1:0] ST_FAIL     = 5'd14;
  localparam logic [STEP_W-1:0] ST_PASS     = 5'd15;
  localparam logic [STEP_W-1:0] ST_FIRST    = 5'd16;
  localparam logic [STEP_W-1:0] ST_END      = 5'd17;
  localparam logic [STEP_W-1:0] ST_FINISH   = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // status from the pair-test datapath
  typedef struct packed {
    logic lt2;
    logic sq_gt;
    logic rem_busy;
    logic rem_zero;
    logic b_zero;
    logic a_one;
  } tst_flags_t;

  // status from the run tracker and channels
  typedef struct packed {
    logic no_item;
    logic first;
    logic mode1;
    logic out_busy;
  } run_flags_t;

  // control store: a jump is taken when the condition holds, else fall through
  function automatic uword_t ucode(input logic [STEP_W-1:0] s);
    uword_t w;
    case (s)
      ST_IDLE:     w = '{OP_NONE,      C_NO_ITEM,  ST_IDLE};
      ST_DISPATCH: w = '{OP_NONE,      C_FIRST,    ST_FIRST};
      ST_SEL_MODE: w = '{OP_NONE,      C_MODE1,    ST_G_LOOP};
      ST_P_INIT:   w = '{OP_P_INIT,    C_LT2,      ST_FAIL};
      ST_P_LOOP:   w = '{OP_NONE,      C_SQ_GT,    ST_PASS};
      ST_P_REM:    w = '{OP_REM_P,     C_NEVER,    ST_IDLE};
      ST_P_WAIT:   w = '{OP_NONE,      C_REM_BUSY, ST_P_WAIT};
      ST_P_CHECK:  w = '{OP_NONE,      C_REM_ZERO, ST_FAIL};
      ST_P_NEXT:   w = '{OP_D_INC,     C_ALWAYS,   ST_P_LOOP};
      ST_G_LOOP:   w = '{OP_NONE,      C_B_ZERO,   ST_G_CHECK};
      ST_G_REM:    w = '{OP_REM_G,     C_NEVER,    ST_IDLE};
      ST_G_WAIT:   w = '{OP_NONE,      C_REM_BUSY, ST_G_WAIT};
      ST_G_STEP:   w = '{OP_GCD_STEP,  C_ALWAYS,   ST_G_LOOP};
      ST_G_CHECK:  w = '{OP_NONE,      C_A_ONE,    ST_PASS};
      ST_FAIL:     w = '{OP_RUN_BREAK, C_ALWAYS,   ST_END};
      ST_PASS:     w = '{OP_RUN_GROW,  C_ALWAYS,   ST_END};
      ST_FIRST:    w = '{OP_RUN_FIRST, C_NEVER,    ST_IDLE};
      ST_END:      w = '{OP_NONE,      C_OUT_BUSY, ST_END};
      ST_FINISH:   w = '{OP_FINISH,    C_ALWAYS,   ST_IDLE};
      default:     w = '{OP_NONE,      C_ALWAYS,   ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- src/longest_run_prime_or_coprime_pairs.sv -----
// ----------------------------------------------------------------------------
// longest_run_prime_or_coprime_pairs: longest run of qualifying neighbours
// Streams an array one element per transaction and reports the start and
// length of the longest run whose neighbour pairs pass the selected test.
// ----------------------------------------------------------------------------
// One element is in flight at a time; the next is taken once the previous
// one has been retired, and a finished result may wait in the output
// register meanwhile. The finish of a last element waits while an earlier
// result still sits unread in the output register. Pair tests share a
// bit-serial remainder unit. In prime-difference mode an element is tried
// against divisors from 2 upward until the square of the divisor exceeds
// the difference, and stops early once a divisor turns up; in coprime mode
// it runs Euclid steps until the second operand is zero. The first element
// of an array skips the pair test, and in prime-difference mode a
// difference below two fails at once.
// The mode register is sampled when an element is taken.
module longest_run_prime_or_coprime_pairs
  import lrpc_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_wr_data,  // pair_test_mode
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] in_tdata,     // value
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [OUT_TDATA_W-1:0]                out_tdata     // run start, run_length
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);

  logic                  mode_r;
  logic                  item_mode_r;
  logic                  item_last_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [VALUE_BITS-1:0] prev_r, prev_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      cur_start_r, cur_start_nxt;
  logic [LEN_W-1:0]      cur_len_r, cur_len_nxt;
  logic [IDX_W-1:0]      best_start_r, best_start_nxt;
  logic [LEN_W-1:0]      best_len_r, best_len_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [START_W-1:0]    out_start_r, out_start_nxt;
  logic [LEN_W_OUT-1:0]  out_len_r, out_len_nxt;

  logic                  accept;
  logic                  idle;
  logic [OP_W-1:0]       op;
  tst_flags_t            tst;
  run_flags_t            run;
  logic                  cur_wins;
  logic [IDX_W-1:0]      fin_start;
  logic [LEN_W-1:0]      fin_len;
  logic [31:0]           fin_start_ext;
  logic [31:0]           fin_len_ext;

  assign in_tready = idle;
  assign accept    = in_tvalid && in_tready;

  assign run.no_item  = !accept;
  assign run.first    = idx_r == '0;
  assign run.mode1    = item_mode_r;
  assign run.out_busy = item_last_r && out_valid_r && !out_tready;

  lrpc_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .tst  (tst),
    .run  (run),
    .op   (op),
    .idle (idle)
  );

  lrpc_test #(
    .VALUE_BITS(VALUE_BITS)
  ) u_test (
    .clk  (clk),
    .rst_n(rst_n),
    .load (accept),
    .mode (mode_r),
    .value(in_tdata[VALUE_BITS-1:0]),
    .prev (prev_r),
    .op   (op),
    .flags(tst)
  );

  // closing the open run against the best one
  assign cur_wins      = cur_len_r > best_len_r;
  assign fin_start     = cur_wins ? cur_start_r : best_start_r;
  assign fin_len       = cur_wins ? cur_len_r : best_len_r;
  assign fin_start_ext = 32'(fin_start);
  assign fin_len_ext   = 32'(fin_len);

  always_comb begin
    prev_nxt       = prev_r;
    idx_nxt        = idx_r;
    cur_start_nxt  = cur_start_r;
    cur_len_nxt    = cur_len_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_start_nxt  = out_start_r;
    out_len_nxt    = out_len_r;
    case (op)
      OP_RUN_FIRST: begin
        cur_start_nxt  = '0;
        cur_len_nxt    = LEN_W'(1);
        best_start_nxt = '0;
        best_len_nxt   = '0;
      end
      OP_RUN_GROW: begin
        if (cur_len_r < LEN_W'(MAX_ELEMENTS)) begin
          cur_len_nxt = cur_len_r + LEN_W'(1);
        end
      end
      OP_RUN_BREAK: begin
        best_start_nxt = fin_start;
        best_len_nxt   = fin_len;
        cur_start_nxt  = idx_r;
        cur_len_nxt    = LEN_W'(1);
      end
      OP_FINISH: begin
        if (item_last_r) begin
          out_valid_nxt  = 1'b1;
          out_start_nxt  = fin_start_ext[START_W-1:0];
          out_len_nxt    = fin_len_ext[LEN_W_OUT-1:0];
          prev_nxt       = '0;
          idx_nxt        = '0;
          cur_start_nxt  = '0;
          cur_len_nxt    = '0;
          best_start_nxt = '0;
          best_len_nxt   = '0;
        end else begin
          prev_nxt = value_r;
          if (idx_r < IDX_W'(MAX_ELEMENTS - 1)) begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      prev_r       <= '0;
      idx_r        <= '0;
      cur_start_r  <= '0;
      cur_len_r    <= '0;
      best_start_r <= '0;
      best_len_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      prev_r       <= prev_nxt;
      idx_r        <= idx_nxt;
      cur_start_r  <= cur_start_nxt;
      cur_len_r    <= cur_len_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // transaction payload and output data
  always_ff @(posedge clk) begin
    if (accept) begin
      value_r     <= in_tdata[VALUE_BITS-1:0];
      item_last_r <= in_tlast;
      item_mode_r <= mode_r;
    end
    out_start_r <= out_start_nxt;
    out_len_r   <= out_len_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - START_W - LEN_W_OUT){1'b0}}, out_len_r, out_start_r};

`ifndef NO_ASSERTIONS
  // a reported run always holds at least one element
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r != '0))
    else $error("empty run reported");

  // the remainder unit is never restarted mid-division
  a_rem_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ((op == OP_REM_P) || (op == OP_REM_G)) |-> !tst.rem_busy)
    else $error("remainder unit restarted while busy");

  // a taken element blocks the input until it is retired
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second element taken while one is in flight");
`endif

endmodule

// ----- src/lrpc_rem.sv -----
// ----------------------------------------------------------------------------
// lrpc_rem: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; gives dividend mod divisor.
// ----------------------------------------------------------------------------
module lrpc_rem #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  busy,
  output logic [VALUE_BITS-1:0] remainder
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] dvd_r, dvd_nxt;
  logic [VALUE_BITS-1:0] dsr_r, dsr_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   trial_sub;

  assign trial     = {rem_r, dvd_r[VALUE_BITS-1]};
  assign trial_sub = trial - {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = trial_sub[VALUE_BITS-1:0];
      end else begin
        rem_nxt = trial[VALUE_BITS-1:0];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign remainder = rem_r;

endmodule

// ----- src/lrpc_test.sv -----
// ----------------------------------------------------------------------------
// lrpc_test: pair-test datapath
// Operand registers, trial divisor and its square, and the shared remainder
// unit; serves both the prime-difference and the coprime test.
// ----------------------------------------------------------------------------
module lrpc_test
  import lrpc_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic                  mode,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [VALUE_BITS-1:0] prev,
  input  logic [OP_W-1:0]       op,
  output tst_flags_t            flags
);

  localparam int SQ_W = VALUE_BITS + 2;

  logic [VALUE_BITS-1:0] a_r, a_nxt;
  logic [VALUE_BITS-1:0] b_r, b_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [VALUE_BITS-1:0] diff;
  logic                  rem_start;
  logic [VALUE_BITS-1:0] rem_divisor;
  logic                  rem_busy;
  logic [VALUE_BITS-1:0] rem_val;

  assign diff = (value > prev) ? (value - prev) : (prev - value);

  always_comb begin
    a_nxt  = a_r;
    b_nxt  = b_r;
    d_nxt  = d_r;
    sq_nxt = sq_r;
    if (load) begin
      a_nxt = mode ? value : diff;
      b_nxt = prev;
    end else begin
      case (op)
        OP_P_INIT: begin
          d_nxt  = VALUE_BITS'(2);
          sq_nxt = SQ_W'(4);
        end
        OP_D_INC: begin
          // (d+1)^2 = d^2 + 2d + 1
          d_nxt  = d_r + VALUE_BITS'(1);
          sq_nxt = sq_r + SQ_W'({d_r, 1'b1});
        end
        OP_GCD_STEP: begin
          a_nxt = b_r;
          b_nxt = rem_val;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    d_r  <= d_nxt;
    sq_r <= sq_nxt;
  end

  assign rem_start   = (op == OP_REM_P) || (op == OP_REM_G);
  assign rem_divisor = (op == OP_REM_G) ? b_r : d_r;

  lrpc_rem #(
    .VALUE_BITS(VALUE_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (a_r),
    .divisor  (rem_divisor),
    .busy     (rem_busy),
    .remainder(rem_val)
  );

  assign flags.lt2      = a_r < VALUE_BITS'(2);
  assign flags.sq_gt    = sq_r > SQ_W'(a_r);
  assign flags.rem_busy = rem_busy;
  assign flags.rem_zero = rem_val == '0;
  assign flags.b_zero   = b_r == '0;
  assign flags.a_one    = a_r == VALUE_BITS'(1);

endmodule

// ----- src/lrpc_seq.sv -----
// ----------------------------------------------------------------------------
// lrpc_seq: microprogram sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module lrpc_seq
  import lrpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  tst_flags_t        tst,
  input  run_flags_t        run,
  output logic [OP_W-1:0]   op,
  output logic              idle
);

  logic [STEP_W-1:0] step_r, step_nxt;
  uword_t            uw;
  logic              taken;

  assign uw = ucode(step_r);

  always_comb begin
    case (uw.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_ITEM:  taken = run.no_item;
      C_FIRST:    taken = run.first;
      C_MODE1:    taken = run.mode1;
      C_LT2:      taken = tst.lt2;
      C_SQ_GT:    taken = tst.sq_gt;
      C_REM_BUSY: taken = tst.rem_busy;
      C_REM_ZERO: taken = tst.rem_zero;
      C_B_ZERO:   taken = tst.b_zero;
      C_A_ONE:    taken = tst.a_one;
      C_OUT_BUSY: taken = run.out_busy;
      default:    taken = 1'b1;
    endcase
    step_nxt = taken ? uw.target : (step_r + STEP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign op   = uw.op;
  assign idle = step_r == ST_IDLE;

endmodule
